### rtl/tbug_pkg.sv
// Shared types and constants for the time based UUID generator.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps

package tbug_pkg;

  localparam int unsigned TIME_W  = 60;
  localparam int unsigned CSEQ_W  = 14;
  localparam int unsigned TICK_W  = 25;
  localparam int unsigned NODE_W  = 48;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CIDX_W  = 1;

  // Sub-tick numbers available within one timestamp tick
  localparam logic [TICK_W-1:0] SEQ_LIMIT = 25'd10000000;
  localparam logic [TICK_W-1:0] SEQ_LAST  = SEQ_LIMIT - 25'd1;

  localparam logic [3:0] UUID_VERSION = 4'h1;
  localparam logic [1:0] UUID_VARIANT = 2'b10;

  typedef enum logic [KIND_W-1:0] {
    KIND_TIME    = 2'd0,
    KIND_CREATE  = 2'd1,
    KIND_RESTORE = 2'd2
  } kind_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_SHARED_MODE = 1'b0,
    CFG_NODE_ID     = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [TIME_W-1:0] stored_time;
    logic [CSEQ_W-1:0] cseq;
    logic [TICK_W-1:0] sub_tick;
  } gen_state_t;

  typedef struct packed {
    logic [63:0]       uuid_high;
    logic [63:0]       uuid_low;
    logic              status;
    logic [CSEQ_W-1:0] clock_seq_now;
    logic [TIME_W-1:0] stored_time_now;
  } gen_result_t;

endpackage

### rtl/tbug_req_if.sv
// Request channel of the time based UUID generator: valid/ready plus item fields.
// Depends on tbug_pkg.
`timescale 1ns / 1ps

interface tbug_req_if
  import tbug_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [TIME_W-1:0] system_time;
  logic [CSEQ_W-1:0] restore_clock_seq;

  modport source (output valid, kind, system_time, restore_clock_seq, input ready);
  modport sink   (input valid, kind, system_time, restore_clock_seq, output ready);
endinterface

### rtl/tbug_rsp_if.sv
// Result channel of the time based UUID generator: valid/ready plus UUID fields.
// Depends on tbug_pkg.
`timescale 1ns / 1ps

interface tbug_rsp_if
  import tbug_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [63:0]       uuid_high;
  logic [63:0]       uuid_low;
  logic              status;
  logic [CSEQ_W-1:0] clock_seq_now;
  logic [TIME_W-1:0] stored_time_now;

  modport source (output valid, uuid_high, uuid_low, status, clock_seq_now,
                  stored_time_now, input ready);
  modport sink   (input valid, uuid_high, uuid_low, status, clock_seq_now,
                  stored_time_now, output ready);
endinterface

### rtl/tbug_core.sv
// Next-state and UUID packing logic for one request of the generator.
// Depends on tbug_pkg.
`timescale 1ns / 1ps

module tbug_core
  import tbug_pkg::*;
(
  input  logic [KIND_W-1:0] kind,
  input  logic [TIME_W-1:0] system_time,
  input  logic [CSEQ_W-1:0] restore_clock_seq,
  input  logic              shared_mode,
  input  logic [NODE_W-1:0] node_id,
  input  gen_state_t        st,
  output gen_state_t        st_nxt,
  output logic              has_result,
  output gen_result_t       res
);

  logic              exhausted;
  logic [TICK_W-1:0] tick_inc;
  logic [TIME_W-1:0] time_plus_tick;
  logic [CSEQ_W-1:0] cseq_inc;
  logic              time_lt;
  logic              time_eq;
  logic [TIME_W-1:0] ts;
  logic              fail;

  assign exhausted      = st.sub_tick[TICK_W-1] || (st.sub_tick >= SEQ_LAST);
  assign tick_inc       = st.sub_tick + {{(TICK_W-1){1'b0}}, 1'b1};
  assign time_plus_tick = st.stored_time + {{(TIME_W-TICK_W){1'b0}}, tick_inc};
  assign cseq_inc       = st.cseq + {{(CSEQ_W-1){1'b0}}, 1'b1};
  assign time_lt        = system_time < st.stored_time;
  assign time_eq        = system_time == st.stored_time;

  always_comb begin
    st_nxt     = st;
    has_result = 1'b0;
    ts         = '0;
    fail       = 1'b0;
    case (kind_t'(kind))
      KIND_TIME: begin
        if (!time_eq) begin
          if (time_lt) begin
            st_nxt.cseq = cseq_inc;
          end
          st_nxt.stored_time = system_time;
          st_nxt.sub_tick    = '0;
        end
      end
      KIND_RESTORE: begin
        st_nxt.stored_time = system_time;
        st_nxt.cseq        = restore_clock_seq;
        st_nxt.sub_tick    = '0;
      end
      KIND_CREATE: begin
        has_result = 1'b1;
        if (shared_mode) begin
          if (exhausted) begin
            // park at -1 until a changed time arrives
            st_nxt.sub_tick = '1;
            fail            = 1'b1;
          end else begin
            st_nxt.sub_tick = tick_inc;
            ts              = time_plus_tick;
          end
        end else if (!time_eq) begin
          if (time_lt) begin
            st_nxt.cseq = cseq_inc;
          end
          st_nxt.stored_time = system_time;
          st_nxt.sub_tick    = '0;
          ts                 = system_time;
        end else if (exhausted) begin
          fail = 1'b1;
        end else begin
          st_nxt.sub_tick = tick_inc;
          ts              = time_plus_tick;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.status          = fail;
    res.clock_seq_now   = st_nxt.cseq;
    res.stored_time_now = st_nxt.stored_time;
    if (fail) begin
      res.uuid_high = '0;
      res.uuid_low  = '0;
    end else begin
      res.uuid_high = {ts[31:0], ts[47:32], UUID_VERSION, ts[59:48]};
      res.uuid_low  = {UUID_VARIANT, st_nxt.cseq, node_id};
    end
  end

endmodule

### rtl/time_based_uuid_generator.sv
// A request is held in the input register and its result in the result register.
// Throughput: one request per cycle, sustained; a stalled result only blocks
// the input once both the input register and the result register are full.
// Time and restore requests give no result. Reset (rst_n low, synchronous)
// clears the config, stored time, clock sequence, sub-tick and both valid flags.
`timescale 1ns / 1ps

module time_based_uuid_generator
  import tbug_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  tbug_req_if.sink          in_chan,
  tbug_rsp_if.source        out_chan,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [NODE_W-1:0] cfg_wdata
);

  logic              shared_mode_r;
  logic [NODE_W-1:0] node_id_r;

  logic              in_valid_r;
  logic [KIND_W-1:0] in_kind_r;
  logic [TIME_W-1:0] in_time_r;
  logic [CSEQ_W-1:0] in_cseq_r;

  gen_state_t        st_r;
  gen_state_t        st_nxt;
  logic              has_result;
  gen_result_t       res;

  logic              out_valid_r;
  gen_result_t       out_r;

  logic              out_free;
  logic              advance;

  assign out_free      = !out_valid_r || out_chan.ready;
  assign advance       = in_valid_r && (!has_result || out_free);
  assign in_chan.ready = !in_valid_r || advance;

  tbug_core u_core (
    .kind              (in_kind_r),
    .system_time       (in_time_r),
    .restore_clock_seq (in_cseq_r),
    .shared_mode       (shared_mode_r),
    .node_id           (node_id_r),
    .st                (st_r),
    .st_nxt            (st_nxt),
    .has_result        (has_result),
    .res               (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shared_mode_r <= 1'b0;
      node_id_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SHARED_MODE: shared_mode_r <= cfg_wdata[0];
        CFG_NODE_ID:     node_id_r     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_kind_r <= in_chan.kind;
      in_time_r <= in_chan.system_time;
      in_cseq_r <= in_chan.restore_clock_seq;
    end
  end

  // Generator state advances with each request leaving the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && has_result) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_r <= res;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.uuid_high       = out_r.uuid_high;
  assign out_chan.uuid_low        = out_r.uuid_low;
  assign out_chan.status          = out_r.status;
  assign out_chan.clock_seq_now   = out_r.clock_seq_now;
  assign out_chan.stored_time_now = out_r.stored_time_now;

endmodule

### dv/uuid_checker.sv
// Scoreboard for the time based UUID generator: watches the request, result
// and register write ports, predicts each UUID and compares it field by field.
// Depends on tbug_pkg.
`timescale 1ns / 1ps

module uuid_checker
  import tbug_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [TIME_W-1:0] in_system_time,
  input  logic [CSEQ_W-1:0] in_restore_clock_seq,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [63:0]       out_uuid_high,
  input  logic [63:0]       out_uuid_low,
  input  logic              out_status,
  input  logic [CSEQ_W-1:0] out_clock_seq_now,
  input  logic [TIME_W-1:0] out_stored_time_now,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [NODE_W-1:0] cfg_wdata,
  output int                error_count,
  output int                pending,
  output int                uuids_checked,
  output int                exhausted_seen
);

  logic              mode_shared;
  logic [NODE_W-1:0] node_reg;
  logic [TIME_W-1:0] tick_time;
  logic [CSEQ_W-1:0] cseq;
  logic [TICK_W-1:0] sub_tick;

  gen_result_t uuid_expect_q[$];

  // Negative counter means the current tick is used up until the time moves
  function automatic logic seq_exhausted();
    return sub_tick[TICK_W-1] || (sub_tick >= SEQ_LAST);
  endfunction

  task automatic predict_request(input logic [KIND_W-1:0] kind,
                                 input logic [TIME_W-1:0] sys_t,
                                 input logic [CSEQ_W-1:0] cs_in);
    logic [TIME_W-1:0] stamp;
    logic              fail;
    gen_result_t       r;
    stamp = '0;
    fail  = 1'b0;
    case (kind)
      KIND_TIME: begin
        if (sys_t != tick_time) begin
          if (sys_t < tick_time) cseq = cseq + 1'b1;
          tick_time = sys_t;
          sub_tick  = '0;
        end
      end
      KIND_RESTORE: begin
        tick_time = sys_t;
        cseq      = cs_in;
        sub_tick  = '0;
      end
      KIND_CREATE: begin
        if (mode_shared) begin
          if (seq_exhausted()) begin
            sub_tick = '1;
            fail     = 1'b1;
          end else begin
            sub_tick = sub_tick + 1'b1;
            stamp    = tick_time + TIME_W'(sub_tick);
          end
        end else if (sys_t < tick_time) begin
          cseq      = cseq + 1'b1;
          tick_time = sys_t;
          sub_tick  = '0;
          stamp     = sys_t;
        end else if (sys_t > tick_time) begin
          tick_time = sys_t;
          sub_tick  = '0;
          stamp     = sys_t;
        end else if (seq_exhausted()) begin
          fail = 1'b1;
        end else begin
          sub_tick = sub_tick + 1'b1;
          stamp    = tick_time + TIME_W'(sub_tick);
        end
        r.uuid_high       = fail ? '0 : {stamp[31:0], stamp[47:32], UUID_VERSION,
                                         stamp[59:48]};
        r.uuid_low        = fail ? '0 : {UUID_VARIANT, cseq, node_reg};
        r.status          = fail;
        r.clock_seq_now   = cseq;
        r.stored_time_now = tick_time;
        uuid_expect_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic report_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    gen_result_t exp_r;
    if (!rst_n) begin
      mode_shared = 1'b0;
      node_reg    = '0;
      tick_time   = '0;
      cseq        = '0;
      sub_tick    = '0;
      uuid_expect_q.delete();
      error_count    = 0;
      uuids_checked  = 0;
      exhausted_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SHARED_MODE: mode_shared = cfg_wdata[0];
          CFG_NODE_ID:     node_reg    = cfg_wdata;
          default: ;
        endcase
      end
      // results first: a result never belongs to a request of the same edge
      if (out_valid && out_ready) begin
        if (uuid_expect_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result: expected none, got %h %h %b", $time,
                   out_uuid_high, out_uuid_low, out_status);
        end else begin
          exp_r = uuid_expect_q.pop_front();
          report_field("uuid_high", exp_r.uuid_high, out_uuid_high);
          report_field("uuid_low", exp_r.uuid_low, out_uuid_low);
          report_field("status", 64'(exp_r.status), 64'(out_status));
          report_field("clock_seq_now", 64'(exp_r.clock_seq_now),
                       64'(out_clock_seq_now));
          report_field("stored_time_now", 64'(exp_r.stored_time_now),
                       64'(out_stored_time_now));
          uuids_checked++;
          if (exp_r.status) exhausted_seen++;
        end
      end
      if (in_valid && in_ready)
        predict_request(in_kind, in_system_time, in_restore_clock_seq);
    end
    pending = uuid_expect_q.size();
  end

endmodule

### dv/tb_top.sv
// Testbench top for time_based_uuid_generator: clock, reset, register writes,
// request stimulus with random idling, and the final verdict.
// Depends on tbug_pkg, tbug_req_if, tbug_rsp_if and uuid_checker.
`timescale 1ns / 1ps

module tb_top;
  import tbug_pkg::*;

  localparam int unsigned       IDLE_PCT      = 27;
  localparam int unsigned       MAX_CYCLES    = 200_000;
  localparam int unsigned       RANDOM_PHASES = 8;
  localparam int unsigned       PHASE_ITEMS   = 225;
  localparam int unsigned       BURST_ITEMS   = 200;
  localparam logic [KIND_W-1:0] KIND_UNUSED   = 2'd3;
  localparam logic [TIME_W-1:0] TIME_MAX      = '1;
  // close enough to the top that the sub-tick sum wraps during the burst
  localparam logic [TIME_W-1:0] BURST_START   = TIME_MAX - 60'd100;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  cfg_idx_t          cfg_index;
  logic [NODE_W-1:0] cfg_wdata;

  logic              in_idle_en;
  logic              out_idle_en;
  logic [TIME_W-1:0] clock_now;
  int                cycle_count;
  int                n_create, n_update, n_restore, n_unused;

  int error_count, pending, uuids_checked, exhausted_seen;

  tbug_req_if req_chan ();
  tbug_rsp_if rsp_chan ();

  time_based_uuid_generator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (req_chan),
    .out_chan  (rsp_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  uuid_checker u_uuid_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (req_chan.valid),
    .in_ready             (req_chan.ready),
    .in_kind              (req_chan.kind),
    .in_system_time       (req_chan.system_time),
    .in_restore_clock_seq (req_chan.restore_clock_seq),
    .out_valid            (rsp_chan.valid),
    .out_ready            (rsp_chan.ready),
    .out_uuid_high        (rsp_chan.uuid_high),
    .out_uuid_low         (rsp_chan.uuid_low),
    .out_status           (rsp_chan.status),
    .out_clock_seq_now    (rsp_chan.clock_seq_now),
    .out_stored_time_now  (rsp_chan.stored_time_now),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .error_count          (error_count),
    .pending              (pending),
    .uuids_checked        (uuids_checked),
    .exhausted_seen       (exhausted_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk) begin
    rsp_chan.ready = !(out_idle_en && ($urandom_range(99) < IDLE_PCT));
  end

  function automatic logic [TIME_W-1:0] rand_time60();
    return TIME_W'({$urandom(), $urandom()});
  endfunction

  // Mostly near the current time so equal, later and earlier cases all occur
  function automatic logic [TIME_W-1:0] pick_time();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40)      return clock_now;
    else if (roll < 65) return clock_now + TIME_W'($urandom_range(1000, 1));
    else if (roll < 80) return clock_now - TIME_W'($urandom_range(1000, 1));
    else if (roll < 90) return rand_time60();
    else if (roll < 95) return '0;
    else                return TIME_MAX;
  endfunction

  task automatic send_req(input logic [KIND_W-1:0] kind,
                          input logic [TIME_W-1:0] stamp,
                          input logic [CSEQ_W-1:0] cs);
    while (in_idle_en && ($urandom_range(99) < IDLE_PCT)) begin
      req_chan.valid = 1'b0;
      @(negedge clk);
    end
    req_chan.valid             = 1'b1;
    req_chan.kind              = kind;
    req_chan.system_time       = stamp;
    req_chan.restore_clock_seq = cs;
    @(posedge clk);
    while (!req_chan.ready) @(posedge clk);
    @(negedge clk);
    if (kind == KIND_CREATE)       n_create++;
    else if (kind == KIND_TIME)    n_update++;
    else if (kind == KIND_RESTORE) n_restore++;
    else                           n_unused++;
    if (kind != KIND_UNUSED) clock_now = stamp;
  endtask

  // Hold until every result is in and the request register has drained
  task automatic wait_drained();
    req_chan.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [NODE_W-1:0] data);
    wait_drained();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic send_random();
    int unsigned       roll;
    logic [CSEQ_W-1:0] cs;
    roll = $urandom_range(99);
    case ($urandom_range(9))
      0:       cs = '0;
      1:       cs = '1;
      default: cs = CSEQ_W'($urandom());
    endcase
    if (roll < 58)      send_req(KIND_CREATE, pick_time(), cs);
    else if (roll < 82) send_req(KIND_TIME, pick_time(), cs);
    else if (roll < 92) send_req(KIND_RESTORE, pick_time(), cs);
    else                send_req(KIND_UNUSED, rand_time60(), cs);
  endtask

  initial begin
    logic [NODE_W-1:0] node;
    rst_n                      = 1'b0;
    cfg_we                     = 1'b0;
    cfg_index                  = CFG_SHARED_MODE;
    cfg_wdata                  = '0;
    req_chan.valid             = 1'b0;
    req_chan.kind              = KIND_TIME;
    req_chan.system_time       = '0;
    req_chan.restore_clock_seq = '0;
    in_idle_en                 = 1'b1;
    out_idle_en                = 1'b1;
    clock_now                  = '0;
    cycle_count                = 0;
    n_create                   = 0;
    n_update                   = 0;
    n_restore                  = 0;
    n_unused                   = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Directed: single mode first
    cfg_write(CFG_NODE_ID, '0);
    cfg_write(CFG_SHARED_MODE, 48'd0);
    send_req(KIND_CREATE, '0, '0);
    send_req(KIND_CREATE, '0, '1);
    send_req(KIND_CREATE, 60'd100, '0);
    send_req(KIND_CREATE, 60'd50, '0);
    send_req(KIND_TIME, 60'd50, '0);
    send_req(KIND_TIME, 60'd40, '0);
    send_req(KIND_TIME, 60'd60, '0);
    send_req(KIND_CREATE, 60'd60, '0);
    send_req(KIND_UNUSED, TIME_MAX, '1);
    send_req(KIND_RESTORE, TIME_MAX, '1);
    send_req(KIND_CREATE, TIME_MAX, '0);
    send_req(KIND_TIME, '0, '0);
    send_req(KIND_RESTORE, 60'hAAAAAAAAAAAAAAA, 14'h1555);
    send_req(KIND_CREATE, 60'h555555555555555, '0);

    // Directed: shared mode, node id all ones
    cfg_write(CFG_NODE_ID, '1);
    cfg_write(CFG_SHARED_MODE, 48'd1);
    send_req(KIND_CREATE, rand_time60(), '0);
    send_req(KIND_CREATE, rand_time60(), '1);
    send_req(KIND_TIME, 60'h555555555555560, '0);
    send_req(KIND_CREATE, '0, '0);
    send_req(KIND_TIME, '0, '0);
    send_req(KIND_CREATE, TIME_MAX, '0);
    send_req(KIND_RESTORE, 60'h0F0F0F0F0F0F0F0, 14'h2AAA);
    send_req(KIND_CREATE, '0, '0);

    // Shared mode near the top of the time range: a back-to-back run of
    // creates whose timestamps wrap past zero, then single mode on the same tick
    node = NODE_W'({$urandom(), $urandom()});
    cfg_write(CFG_NODE_ID, node);
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    send_req(KIND_RESTORE, BURST_START, CSEQ_W'($urandom()));
    repeat (BURST_ITEMS) send_req(KIND_CREATE, BURST_START, '0);
    send_req(KIND_TIME, BURST_START, '0);
    send_req(KIND_CREATE, BURST_START, '0);
    cfg_write(CFG_SHARED_MODE, 48'd0);
    send_req(KIND_CREATE, BURST_START, '0);
    send_req(KIND_CREATE, BURST_START + 60'd1, '0);
    send_req(KIND_CREATE, BURST_START + 60'd1, '0);
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;

    // Random phases over both modes and a spread of node ids
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 3)
        0:       node = '1;
        1:       node = '0;
        default: node = NODE_W'({$urandom(), $urandom()});
      endcase
      cfg_write(CFG_NODE_ID, node);
      cfg_write(CFG_SHARED_MODE, 48'(p % 2));
      in_idle_en  = (p != 2);
      out_idle_en = (p != 2);
      repeat (PHASE_ITEMS) send_random();
    end

    wait_drained();
    $display("Sent %0d creates, %0d time updates, %0d restores, %0d unused kinds.",
             n_create, n_update, n_restore, n_unused);
    $display("Checked %0d UUID results, %0d of them reporting exhaustion.",
             uuids_checked, exhausted_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
